// ===== hw/rtl/rwsf_pkg.sv =====
// Shared types and constants of the read watch scan filter.
package rwsf_pkg;

  localparam int WIN_BYTES   = 4096;
  localparam int OFF_W       = $clog2(WIN_BYTES);
  localparam int FLOAD_W     = 15;
  localparam int FLOAD_LIMIT = 16384;
  localparam int SWEEP_RUN   = 16;
  localparam int PEND_DEPTH  = SWEEP_RUN - 1;
  localparam int RUN_W       = 5;
  localparam int K_W         = 4;
  localparam int CNT_W       = 32;
  localparam int SIZE_W      = 13;
  localparam int CFG_IDX_W   = 3;

  // Request codes.
  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_FRAME = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;
  localparam logic [1:0] REQ_CLEAR = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_BASE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WATCH_ENABLE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_MODE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_ENABLE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_OFFSET = 3'd4;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [31:0]      address;
    logic [OFF_W-1:0] entry_index;
  } in_item_t;

  typedef struct packed {
    logic              result_kind;
    logic              frame_evaluated;
    logic              set_changed;
    logic [SIZE_W-1:0] set_size;
    logic [31:0]       frame_number;
    logic              trigger_fired;
    logic [31:0]       entry_count;
    logic              entry_in_set;
    logic [31:0]       total_loads;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             capture;
    logic [OFF_W-1:0] addr;
    logic [K_W-1:0]   k;
    logic             init_wr;
    logic             bc_clr_wr;
    logic             cnt_rd;
    logic             cnt_wr;
    logic             total_inc;
    logic             floads_inc;
    logic             run_extend;
    logic             run_start;
    logic             run_clear;
    logic             close_mark;
    logic             frame_begin;
    logic             sweep_rd;
    logic             frame_commit;
    logic             rd_issue;
    logic             emit_rd;
    logic             emit_sum;
    logic             eval;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0]       req_type;
    logic             watch;
    logic             count_mode;
    logic             in_win;
    logic             frame_full;
    logic             floads_zero;
    logic             extend;
    logic [RUN_W-1:0] run_len;
  } sts_t;

endpackage

// ===== hw/rtl/read_watch_scan_filter.sv =====
// Top level of the read watch scan filter.
//
// Usage: requests enter on the in_ channel (valid/stall); a transfer happens
// when in_valid is high and in_stall is low. Loads (type 0) and clears
// (type 3) give no result; frame ends (type 1) and readouts (type 2) give one
// result on the out_ channel, held in an output register until transferred.
// Configuration must be written through cfg_we/cfg_index/cfg_wdata only while
// idle; the block does not enforce this. A load passes capture and dispatch;
// counting mode adds a counter write state for the read-modify-write, and
// closing a short run adds a close state marking each pending offset. A readout
// result is written once the output register is free. An evaluated frame end
// closes the open run and then walks both 4096-entry bitmaps one entry a cycle.
// A clear in counting mode zeroes the per-byte counters. After reset a clearing
// pass zeroes all three memories with in_stall high; configuration writes are
// taken during it. While out_stall holds a result, the block keeps taking
// requests that give no result and waits before writing a new one.
module read_watch_scan_filter (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [rwsf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                     cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  rwsf_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output rwsf_pkg::out_item_t             out_data
);
  import rwsf_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rwsf_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
  );

  rwsf_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .in_data(in_data), .cmd(cmd), .sts(sts),
    .out_data(out_data)
  );
endmodule

// ===== hw/rtl/rwsf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rwsf_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

// ===== hw/rtl/rwsf_dp.sv =====
// Datapath: configuration, run tracking, counters, bitmaps and result register.
module rwsf_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [rwsf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                     cfg_wdata,
  input  rwsf_pkg::in_item_t              in_data,
  input  rwsf_pkg::cmd_t                  cmd,
  output rwsf_pkg::sts_t                  sts,
  output rwsf_pkg::out_item_t             out_data
);
  import rwsf_pkg::*;

  logic [31:0]      window_base_r;
  logic             watch_enable_r;
  logic             count_mode_r;
  logic             trigger_enable_r;
  logic [OFF_W-1:0] trigger_offset_r;

  in_item_t         in_r;
  out_item_t        out_r;
  logic [OFF_W-1:0] pend_r [PEND_DEPTH];
  logic [RUN_W-1:0] run_len_r;
  logic [OFF_W-1:0] last_off_r;
  logic [FLOAD_W-1:0] floads_r;
  logic [31:0]      frame_cnt_r;
  logic             have_rep_r;
  logic             trig_flag_r;
  logic [31:0]      total_r;
  logic             sw_v_r;
  logic [OFF_W-1:0] sw_a_r;
  logic             diff_r;
  logic [SIZE_W-1:0] size_r;
  logic             hit_r;
  logic             changed_r;

  logic [31:0]      off;
  logic [OFF_W-1:0] off12;
  logic [CNT_W-1:0] bc_rd;
  logic [CNT_W-1:0] bc_sat;
  logic             fs_rd;
  logic             rs_rd;

  logic             bc_we;
  logic [OFF_W-1:0] bc_waddr;
  logic [CNT_W-1:0] bc_wdata;
  logic [OFF_W-1:0] bc_raddr;
  logic             fs_we;
  logic [OFF_W-1:0] fs_waddr;
  logic             rs_we;
  logic [OFF_W-1:0] rs_waddr;
  logic [OFF_W-1:0] rs_raddr;

  // Window offset of the held load.
  assign off   = in_r.address - window_base_r;
  assign off12 = off[OFF_W-1:0];
  assign bc_sat = (bc_rd == {CNT_W{1'b1}}) ? bc_rd : bc_rd + CNT_W'(1);

  // Status to the controller.
  always_comb begin
    sts.req_type    = in_r.req_type;
    sts.watch       = watch_enable_r;
    sts.count_mode  = count_mode_r;
    sts.in_win      = (off[31:OFF_W] == '0);
    sts.frame_full  = (floads_r >= FLOAD_W'(FLOAD_LIMIT));
    sts.floads_zero = (floads_r == '0);
    sts.extend      = (run_len_r != '0) &&
                      ({1'b0, off12} == ({1'b0, last_off_r} + (OFF_W+1)'(1)));
    sts.run_len     = run_len_r;
  end

  // Memory port selection.
  always_comb begin
    bc_we    = cmd.init_wr | cmd.bc_clr_wr | cmd.cnt_wr;
    bc_waddr = cmd.cnt_wr ? off12 : cmd.addr;
    bc_wdata = cmd.cnt_wr ? bc_sat : '0;
    bc_raddr = cmd.cnt_rd ? off12 : in_r.entry_index;
    fs_we    = cmd.init_wr | cmd.close_mark | sw_v_r;
    fs_waddr = cmd.close_mark ? pend_r[cmd.k] : (sw_v_r ? sw_a_r : cmd.addr);
    rs_we    = cmd.init_wr | sw_v_r;
    rs_waddr = sw_v_r ? sw_a_r : cmd.addr;
    rs_raddr = cmd.sweep_rd ? cmd.addr : in_r.entry_index;
  end

  rwsf_ram #(.WIDTH(CNT_W), .DEPTH(WIN_BYTES)) u_byte_counts (
    .clk(clk), .we(bc_we), .waddr(bc_waddr), .wdata(bc_wdata),
    .re(cmd.cnt_rd | cmd.rd_issue), .raddr(bc_raddr), .rdata(bc_rd)
  );

  rwsf_ram #(.WIDTH(1), .DEPTH(WIN_BYTES)) u_frame_set (
    .clk(clk), .we(fs_we), .waddr(fs_waddr), .wdata(cmd.close_mark),
    .re(cmd.sweep_rd), .raddr(cmd.addr), .rdata(fs_rd)
  );

  rwsf_ram #(.WIDTH(1), .DEPTH(WIN_BYTES)) u_reported_set (
    .clk(clk), .we(rs_we), .waddr(rs_waddr), .wdata(sw_v_r & fs_rd),
    .re(cmd.sweep_rd | cmd.rd_issue), .raddr(rs_raddr), .rdata(rs_rd)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_base_r    <= '0;
      watch_enable_r   <= 1'b0;
      count_mode_r     <= 1'b0;
      trigger_enable_r <= 1'b0;
      trigger_offset_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WINDOW_BASE:    window_base_r    <= cfg_wdata;
        CFG_WATCH_ENABLE:   watch_enable_r   <= cfg_wdata[0];
        CFG_COUNT_MODE:     count_mode_r     <= cfg_wdata[0];
        CFG_TRIGGER_ENABLE: trigger_enable_r <= cfg_wdata[0];
        CFG_TRIGGER_OFFSET: trigger_offset_r <= cfg_wdata[OFF_W-1:0];
        default: ;
      endcase
    end
  end

  // Held item, pending run entries and the result register.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_r <= in_data;
    end
    if (cmd.run_start) begin
      pend_r[0] <= off12;
    end else if (cmd.run_extend && run_len_r < RUN_W'(PEND_DEPTH)) begin
      pend_r[run_len_r[K_W-1:0]] <= off12;
    end
    if (cmd.emit_sum) begin
      out_r.result_kind     <= 1'b0;
      out_r.frame_evaluated <= cmd.eval;
      out_r.set_changed     <= cmd.eval & changed_r;
      out_r.set_size        <= cmd.eval ? size_r : '0;
      out_r.frame_number    <= frame_cnt_r;
      out_r.trigger_fired   <= trig_flag_r;
      out_r.entry_count     <= '0;
      out_r.entry_in_set    <= 1'b0;
      out_r.total_loads     <= total_r;
    end else if (cmd.emit_rd) begin
      out_r.result_kind     <= 1'b1;
      out_r.frame_evaluated <= 1'b0;
      out_r.set_changed     <= 1'b0;
      out_r.set_size        <= '0;
      out_r.frame_number    <= frame_cnt_r;
      out_r.trigger_fired   <= trig_flag_r;
      out_r.entry_count     <= bc_rd[31:0];
      out_r.entry_in_set    <= rs_rd;
      out_r.total_loads     <= total_r;
    end
    sw_a_r <= cmd.addr;
  end

  // Run, frame and sweep state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_len_r   <= '0;
      last_off_r  <= '0;
      floads_r    <= '0;
      frame_cnt_r <= '0;
      have_rep_r  <= 1'b0;
      trig_flag_r <= 1'b0;
      total_r     <= '0;
      sw_v_r      <= 1'b0;
      diff_r      <= 1'b0;
      size_r      <= '0;
      hit_r       <= 1'b0;
      changed_r   <= 1'b0;
    end else begin
      sw_v_r <= cmd.sweep_rd;
      if (cmd.total_inc && total_r != 32'hFFFF_FFFF) begin
        total_r <= total_r + 32'd1;
      end
      if (cmd.floads_inc) begin
        floads_r <= floads_r + FLOAD_W'(1);
      end else if (cmd.frame_commit) begin
        floads_r <= '0;
      end
      // Run tracking.
      if (cmd.run_start) begin
        run_len_r  <= RUN_W'(1);
        last_off_r <= off12;
      end else if (cmd.run_extend) begin
        if (run_len_r < RUN_W'(SWEEP_RUN)) begin
          run_len_r <= run_len_r + RUN_W'(1);
        end
        last_off_r <= off12;
      end else if (cmd.run_clear) begin
        run_len_r <= '0;
      end
      // Bitmap sweep accumulation.
      if (cmd.frame_begin) begin
        frame_cnt_r <= frame_cnt_r + 32'd1;
        diff_r      <= 1'b0;
        size_r      <= '0;
        hit_r       <= 1'b0;
      end else if (sw_v_r) begin
        if (fs_rd != rs_rd) begin
          diff_r <= 1'b1;
        end
        size_r <= size_r + SIZE_W'(fs_rd);
        if (fs_rd && sw_a_r == trigger_offset_r) begin
          hit_r <= 1'b1;
        end
      end
      if (cmd.frame_commit) begin
        changed_r  <= !have_rep_r || diff_r;
        have_rep_r <= 1'b1;
        if (trigger_enable_r && hit_r) begin
          trig_flag_r <= 1'b1;
        end
      end
    end
  end

  assign out_data = out_r;
endmodule

// ===== hw/rtl/rwsf_ctrl.sv =====
// Controller: sequences loads, run closing, bitmap sweeps, clears and results.
module rwsf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  rwsf_pkg::sts_t      sts,
  output rwsf_pkg::cmd_t      cmd
);
  import rwsf_pkg::*;

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_DISP, ST_CNT_WR, ST_CLOSE, ST_FSWEEP,
    ST_FDRAIN, ST_FCOMMIT, ST_EMIT_SUM, ST_EMIT_RD, ST_CLR
  } state_t;

  state_t            state_r, state_nxt;
  logic [OFF_W-1:0]  addr_r, addr_nxt;
  logic [K_W-1:0]    k_r, k_nxt;
  logic              fclose_r, fclose_nxt;
  logic              eval_r, eval_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_free;
  logic              close_done;
  logic              addr_last;

  assign out_free   = !out_valid_r || !out_stall;
  assign close_done = (sts.run_len >= RUN_W'(SWEEP_RUN)) || ({1'b0, k_r} >= sts.run_len);
  assign addr_last  = (addr_r == OFF_W'(WIN_BYTES - 1));
  assign in_stall   = (state_r != ST_IDLE);

  // Next state and commands.
  always_comb begin
    state_nxt  = state_r;
    addr_nxt   = addr_r;
    k_nxt      = k_r;
    fclose_nxt = fclose_r;
    eval_nxt   = eval_r;
    cmd        = '0;
    cmd.addr   = addr_r;
    cmd.k      = k_r;
    cmd.eval   = eval_r;
    unique case (state_r)
      ST_INIT: begin
        cmd.init_wr = 1'b1;
        addr_nxt    = addr_r + OFF_W'(1);
        if (addr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_DISP;
        end
      end
      ST_DISP: begin
        addr_nxt  = '0;
        k_nxt     = '0;
        state_nxt = ST_IDLE;
        unique case (sts.req_type)
          REQ_LOAD: begin
            if (sts.watch && sts.in_win) begin
              cmd.total_inc = 1'b1;
              if (sts.count_mode) begin
                cmd.cnt_rd = 1'b1;
                state_nxt  = ST_CNT_WR;
              end else if (!sts.frame_full) begin
                cmd.floads_inc = 1'b1;
                if (sts.extend) begin
                  cmd.run_extend = 1'b1;
                end else if (sts.run_len == '0 || sts.run_len >= RUN_W'(SWEEP_RUN)) begin
                  cmd.run_start = 1'b1;
                end else begin
                  fclose_nxt = 1'b0;
                  state_nxt  = ST_CLOSE;
                end
              end
            end
          end
          REQ_FRAME: begin
            if (!sts.watch || sts.count_mode || sts.floads_zero) begin
              eval_nxt  = 1'b0;
              state_nxt = ST_EMIT_SUM;
            end else begin
              cmd.frame_begin = 1'b1;
              fclose_nxt      = 1'b1;
              eval_nxt        = 1'b1;
              state_nxt       = ST_CLOSE;
            end
          end
          REQ_READ: begin
            cmd.rd_issue = 1'b1;
            state_nxt    = ST_EMIT_RD;
          end
          REQ_CLEAR: begin
            if (sts.count_mode) state_nxt = ST_CLR;
          end
          default: ;
        endcase
      end
      ST_CNT_WR: begin
        cmd.cnt_wr = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_CLOSE: begin
        if (close_done) begin
          if (fclose_r) begin
            cmd.run_clear = 1'b1;
            state_nxt     = ST_FSWEEP;
          end else begin
            cmd.run_start = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end else begin
          cmd.close_mark = 1'b1;
          k_nxt          = k_r + K_W'(1);
        end
      end
      ST_FSWEEP: begin
        cmd.sweep_rd = 1'b1;
        addr_nxt     = addr_r + OFF_W'(1);
        if (addr_last) state_nxt = ST_FDRAIN;
      end
      ST_FDRAIN: begin
        state_nxt = ST_FCOMMIT;
      end
      ST_FCOMMIT: begin
        cmd.frame_commit = 1'b1;
        state_nxt        = ST_EMIT_SUM;
      end
      ST_EMIT_SUM: begin
        if (out_free) begin
          cmd.emit_sum = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_EMIT_RD: begin
        if (out_free) begin
          cmd.emit_rd = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      ST_CLR: begin
        cmd.bc_clr_wr = 1'b1;
        addr_nxt      = addr_r + OFF_W'(1);
        if (addr_last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Result valid flag.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit_sum || cmd.emit_rd) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      addr_r      <= '0;
      k_r         <= '0;
      fclose_r    <= 1'b0;
      eval_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      k_r         <= k_nxt;
      fclose_r    <= fclose_nxt;
      eval_r      <= eval_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
endmodule

// ===== tb/sv/tb_read_watch_scan_filter.sv =====
// Self-checking testbench for the read watch scan filter: predicted results vs. DUT.
`timescale 1ns / 100ps

module tb_read_watch_scan_filter;
  import rwsf_pkg::*;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_wdata;
  logic                 in_valid;
  logic                 in_stall;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_stall;
  out_item_t            out_data;

  read_watch_scan_filter DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // Settle time covering the slowest result-less work (the counter clear).
  localparam int SETTLE_CYCLES = 4400;

  // Predictor copy of the configuration.
  logic [31:0]      win_base;
  logic             watch_on;
  logic             counting;
  logic             trig_armed;
  logic [OFF_W-1:0] trig_off;

  // Predictor copy of the block state.
  bit               frame_bits [WIN_BYTES];
  bit               shown_bits [WIN_BYTES];
  logic [OFF_W-1:0] run_offs [PEND_DEPTH];
  int unsigned      run_len;
  int unsigned      last_off;
  int unsigned      frame_load_cnt;
  logic [31:0]      frame_cnt;
  bit               shown_valid;
  bit               trig_seen;
  logic [31:0]      byte_cnt [WIN_BYTES];
  logic [31:0]      load_cnt;

  out_item_t pending_results [$];
  int        mismatches;
  int        burst_left;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog.
  initial begin
    #50_000_000;
    $display("status: fail");
    $finish;
  end

  // Flush the open run into the frame set unless it grew into a sweep.
  function automatic void close_open_run();
    if (run_len < SWEEP_RUN) begin
      for (int k = 0; k < run_len && k < PEND_DEPTH; k++) frame_bits[run_offs[k]] = 1'b1;
    end
    run_len = 0;
  endfunction

  function automatic void model_load(logic [31:0] addr);
    logic [31:0] off;
    off = addr - win_base;
    if (!watch_on || off >= WIN_BYTES) return;
    if (load_cnt != 32'hFFFF_FFFF) load_cnt++;
    if (counting) begin
      if (byte_cnt[off] != 32'hFFFF_FFFF) byte_cnt[off]++;
      return;
    end
    if (frame_load_cnt >= FLOAD_LIMIT) return;
    frame_load_cnt++;
    if (run_len > 0 && off == last_off + 1) begin
      if (run_len < SWEEP_RUN) begin
        if (run_len < PEND_DEPTH) run_offs[run_len] = off[OFF_W-1:0];
        run_len++;
      end
    end else begin
      close_open_run();
      run_offs[0] = off[OFF_W-1:0];
      run_len = 1;
    end
    last_off = off;
  endfunction

  function automatic void model_frame_end(ref out_item_t r);
    int unsigned size;
    bit          diff;
    size = 0;
    diff = 0;
    if (!watch_on || counting || frame_load_cnt == 0) return;
    frame_cnt++;
    close_open_run();
    if (trig_armed && !trig_seen && frame_bits[trig_off]) trig_seen = 1'b1;
    for (int i = 0; i < WIN_BYTES; i++) begin
      if (frame_bits[i] != shown_bits[i]) diff = 1;
      size += frame_bits[i];
      shown_bits[i] = frame_bits[i];
      frame_bits[i] = 1'b0;
    end
    r.frame_evaluated = 1'b1;
    r.set_changed = diff || !shown_valid;
    r.set_size = size[SIZE_W-1:0];
    shown_valid = 1'b1;
    frame_load_cnt = 0;
  endfunction

  // Apply one accepted request to the predictor; queue the result it causes.
  function automatic void predict_request(in_item_t it);
    out_item_t r;
    r = '0;
    case (it.req_type)
      REQ_LOAD: model_load(it.address);
      REQ_CLEAR: begin
        if (counting) foreach (byte_cnt[i]) byte_cnt[i] = '0;
      end
      default: begin
        if (it.req_type == REQ_FRAME) begin
          model_frame_end(r);
        end else begin
          r.result_kind = 1'b1;
          r.entry_count = byte_cnt[it.entry_index];
          r.entry_in_set = shown_bits[it.entry_index];
        end
        r.frame_number = frame_cnt;
        r.trigger_fired = trig_seen;
        r.total_loads = load_cnt;
        pending_results.push_back(r);
      end
    endcase
  endfunction

  // Result checker: the transfer happens at the next rising edge.
  always @(negedge clk) begin
    out_item_t e;
    string     bad;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data);
      end else begin
        e = pending_results.pop_front();
        bad = "";
        if (e.result_kind != out_data.result_kind) bad = {bad, " result_kind"};
        if (e.frame_evaluated != out_data.frame_evaluated) bad = {bad, " frame_evaluated"};
        if (e.set_changed != out_data.set_changed) bad = {bad, " set_changed"};
        if (e.set_size != out_data.set_size) bad = {bad, " set_size"};
        if (e.frame_number != out_data.frame_number) bad = {bad, " frame_number"};
        if (e.trigger_fired != out_data.trigger_fired) bad = {bad, " trigger_fired"};
        if (e.entry_count != out_data.entry_count) bad = {bad, " entry_count"};
        if (e.entry_in_set != out_data.entry_in_set) bad = {bad, " entry_in_set"};
        if (e.total_loads != out_data.total_loads) bad = {bad, " total_loads"};
        if (bad != "") begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch in%s: expected %p actual %p", bad, e, out_data);
        end
      end
    end
  end

  // Receiver back-pressure: quiet stretches, random stalls and long holds.
  int stall_mode;
  int stall_hold;
  int mode_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_mode <= 0;
      stall_hold <= 0;
      mode_left <= 0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        mode_left <= $urandom_range(50, 400);
      end else begin
        mode_left <= mode_left - 1;
      end
      if (stall_hold > 0) begin
        stall_hold <= stall_hold - 1;
        out_stall <= 1'b1;
      end else if (stall_mode == 1) begin
        out_stall <= ($urandom_range(0, 2) == 0);
      end else if (stall_mode == 2 && $urandom_range(0, 15) == 0) begin
        stall_hold <= $urandom_range(1, 25);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Send one request and wait for its transfer; then maybe open a gap.
  task automatic send_request(input in_item_t it);
    in_valid <= 1'b1;
    in_data <= it;
    forever begin
      @(negedge clk);
      if (!in_stall) break;
    end
    predict_request(it);
    @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  endtask

  task automatic send_load(input logic [31:0] addr);
    in_item_t it;
    it = '0;
    it.req_type = REQ_LOAD;
    it.address = addr;
    it.entry_index = OFF_W'($urandom);
    send_request(it);
  endtask

  task automatic send_op(input logic [1:0] op, input logic [OFF_W-1:0] idx);
    in_item_t it;
    it.req_type = op;
    it.address = $urandom;
    it.entry_index = idx;
    send_request(it);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Reprogram every register once the block has gone quiet.
  task automatic program_regs(input logic [31:0] base, input logic en, input logic cm,
                              input logic ten, input logic [OFF_W-1:0] toff);
    logic [31:0] vals [5];
    in_valid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    vals = '{base, {31'd0, en}, {31'd0, cm}, {31'd0, ten}, {20'd0, toff}};
    for (int i = 0; i < 5; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= i[CFG_IDX_W-1:0];
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    win_base = base;
    watch_on = en;
    counting = cm;
    trig_armed = ten;
    trig_off = toff;
  endtask

  // Watching off: loads ignored, frame end skipped.
  task automatic test_disabled();
    send_load(32'd3);
    send_load(32'd4);
    send_op(REQ_FRAME, '0);
    send_op(REQ_READ, 12'd3);
    send_op(REQ_CLEAR, '0);
  endtask

  // Short runs, sweeps, window edges, trigger, runs across frames.
  task automatic test_filtered_directed();
    logic [31:0] b;
    b = 32'h1000_0000;
    program_regs(b, 1'b1, 1'b0, 1'b1, 12'd5);
    send_op(REQ_FRAME, '0);                          // no loads yet: skipped
    send_load(b + 5);
    send_load(b + 7); send_load(b + 8); send_load(b + 9);
    for (int i = 0; i < 18; i++) send_load(b + 100 + i); // sweep, dropped
    send_load(b - 1);
    send_load(b + 4095);
    send_load(b + 4096);
    send_load(b);                                    // 4095 then 0 is no run
    send_load(b + 200); send_load(b + 201);
    send_op(REQ_FRAME, '0);
    send_load(b + 202);
    send_op(REQ_FRAME, '0);
    send_load(b + 202);
    send_op(REQ_FRAME, '0);                          // same set again
    send_op(REQ_READ, 12'd202);
    send_op(REQ_READ, 12'd4095);
    send_op(REQ_CLEAR, '0);                          // no effect when filtering
    send_op(REQ_READ, 12'd0);
  endtask

  // Counting mode with a window that wraps past the top of the address space.
  task automatic test_count_mode();
    logic [31:0] b;
    b = 32'hFFFF_F800;
    program_regs(b, 1'b1, 1'b1, 1'b0, 12'd4095);
    send_load(32'hFFFF_FFFF);
    send_load(32'h0000_0000);
    send_load(32'h0000_0000);
    send_load(32'h0000_07FF);
    send_load(32'h0000_0800);
    send_op(REQ_FRAME, '0);                          // skipped in counting mode
    send_op(REQ_READ, 12'd2047);
    send_op(REQ_READ, 12'd2048);
    send_op(REQ_READ, 12'd4095);
    send_op(REQ_CLEAR, '0);
    send_op(REQ_READ, 12'd2048);
  endtask

  // Random traffic: mostly runs of consecutive offsets, plus noise.
  task automatic run_random_phase(input int n_items, input bit drain_midway);
    int sent;
    int pick;
    int len;
    logic [31:0] start;
    sent = 0;
    while (sent < n_items) begin
      if (drain_midway && sent == n_items / 2) begin
        in_valid <= 1'b0;
        wait_drained();
      end
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(14, 20) : $urandom_range(1, 5);
        start = ($urandom_range(0, 7) == 0) ? 4096 - $urandom_range(1, 8)
                                            : $urandom_range(0, 63);
        for (int k = 0; k < len; k++) send_load(win_base + start + k);
        sent += len;
      end else begin
        if (pick < 75) send_load($urandom);
        else if (pick < 78) send_load(win_base + $urandom_range(0, 4095));
        else if (pick < 95) send_op(REQ_READ, ($urandom_range(0, 3) == 0) ? OFF_W'($urandom)
                                               : OFF_W'($urandom_range(0, 70)));
        else if (pick < 99) send_op(REQ_FRAME, OFF_W'($urandom));
        else send_op(REQ_CLEAR, OFF_W'($urandom));
        sent++;
      end
    end
  endtask

  task automatic test_random();
    program_regs(32'd0, 1'b1, 1'b0, 1'b1, 12'd0);
    run_random_phase(400, 1'b1);
    program_regs(32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1, 12'd4095);
    run_random_phase(300, 1'b0);
    program_regs($urandom, 1'b1, 1'b1, 1'b1, OFF_W'($urandom));
    run_random_phase(250, 1'b0);
    program_regs($urandom, 1'b1, 1'b0, 1'b0, 12'd3);
    run_random_phase(350, 1'b0);
    program_regs(32'd0, 1'b0, 1'b0, 1'b1, 12'd1);
    run_random_phase(100, 1'b0);
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    mismatches = 0;
    burst_left = 0;
    win_base = '0; watch_on = 0; counting = 0; trig_armed = 0; trig_off = '0;
    foreach (byte_cnt[i]) begin
      byte_cnt[i] = '0;
      frame_bits[i] = 0;
      shown_bits[i] = 0;
    end
    foreach (run_offs[i]) run_offs[i] = '0;
    run_len = 0; last_off = 0; frame_load_cnt = 0; frame_cnt = '0;
    shown_valid = 0; trig_seen = 0; load_cnt = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_disabled();
    test_filtered_directed();
    test_count_mode();
    test_random();

    in_valid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
